/* hw/rtl/stbs_pkg.sv */
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int VALUE_W     = 32;
    localparam int ACTION_W    = 2;
    localparam int POS_W       = 6;
    localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [POS_W-1:0] position;
    } stbs_res_t;

endpackage

/* hw/rtl/stbs_core.sv */
`timescale 1ns / 1ps

module stbs_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stbs_pkg::ACTION_W-1:0]       in_action,
    input  logic signed [stbs_pkg::VALUE_W-1:0] in_value,
    output stbs_pkg::stbs_res_t                 res,
    input  logic                                res_ready
);
    import stbs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hix_reg, hix_next;
    logic [ADDR_W-1:0]         mid_reg, mid_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic                      found_reg, found_next;

    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      mem_we;
    logic [ADDR_W-1:0]         wr_addr;
    logic [CNT_W:0]            span_sum;
    logic [ADDR_W-1:0]         mid_calc;
    logic                      accept;
    logic                      full;

    // hix is one past the upper bound
    assign span_sum = {1'b0, lo_reg} + {1'b0, hix_reg} - (CNT_W + 1)'(1);
    assign mid_calc = span_sum[ADDR_W:1];
    assign wr_addr  = count_reg[ADDR_W-1:0];
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= in_value;
        end
        rd_data_reg <= mem[mid_calc];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hix_next   = hix_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        found_next = found_reg;
        mem_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (!full)
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_SEARCH:
                        begin
                            key_next   = in_value;
                            lo_next    = '0;
                            hix_next   = count_reg;
                            mid_next   = '0;
                            found_next = 1'b0;
                            state_next = ST_PROBE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hix_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_CMP;
                end
                else
                begin
                    mid_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                priority if (key_reg == rd_data_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (key_reg < rd_data_reg)
                begin
                    hix_next   = {1'b0, mid_reg};
                    state_next = ST_PROBE;
                end
                else
                begin
                    lo_next    = {1'b0, mid_reg} + CNT_W'(1);
                    state_next = ST_PROBE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hix_reg   <= hix_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
    end

    assign res.valid    = (state_reg == ST_DONE);
    assign res.found    = found_reg;
    assign res.position = POS_W'(mid_reg);

endmodule

/* hw/rtl/sorted_table_binary_search_unit.sv */
`timescale 1ns / 1ps
// Clear and append items are handled without leaving idle; the next item is taken the following cycle.
// A search repeats probes (a registered table read, then a compare) until a hit or an empty range,
// over a table of up to 64 entries; the result is then loaded into the output register.
// A finished result sits in the output register while the next item is taken.
// Reset clears the entry count and the output valid; table contents are undefined.
module sorted_table_binary_search_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [stbs_pkg::VALUE_W-1:0]        s_axis_tdata,  // value
    input  logic [stbs_pkg::ACTION_W-1:0]       s_axis_tuser,  // action
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [stbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // position
    output logic [0:0]                          m_axis_tuser   // found
);
    import stbs_pkg::*;

    stbs_res_t        res;
    logic             res_ready;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg;
    logic [POS_W-1:0] pos_reg;
    logic             load;

    stbs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_value  (signed'(s_axis_tdata)),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;
    assign load      = res.valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= res.found;
            pos_reg   <= res.position;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_TDATA_W'(pos_reg);
    assign m_axis_tuser[0] = found_reg;

endmodule
